>>> src/atem_pkg.sv
// ----------------------------------------------------------------------------
// atem_pkg - alarm time entry and match, shared types and constants
// Item, state and result layouts, kind and key codes, digit limits.
// ----------------------------------------------------------------------------
package atem_pkg;

    // item kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_EDIT = 2'd0;
    localparam t_kind KIND_KEY  = 2'd1;
    localparam t_kind KIND_TIME = 2'd2;

    // edit target codes
    localparam logic [1:0] EDIT_NONE = 2'd0;
    localparam logic [1:0] EDIT_A1   = 2'd1;
    localparam logic [1:0] EDIT_A2   = 2'd2;

    // cursor positions
    localparam logic [1:0] POS_HT = 2'd0;
    localparam logic [1:0] POS_HO = 2'd1;
    localparam logic [1:0] POS_MT = 2'd2;
    localparam logic [1:0] POS_MO = 2'd3;

    // command keys
    localparam logic [3:0] KEY_STAR = 4'd11;
    localparam logic [3:0] KEY_HASH = 4'd12;

    // digit limits (exclusive)
    localparam logic [3:0] HT_LIMIT    = 4'd3;
    localparam logic [3:0] HO_LIMIT_20 = 4'd4;
    localparam logic [3:0] MT_LIMIT    = 4'd6;
    localparam logic [3:0] DIGIT_LIMIT = 4'd10;
    localparam logic [1:0] HT_TWENTY   = 2'd2;

    // HH:MM as four digits, each as narrow as its range allows
    typedef struct packed {
        logic [1:0] ht;
        logic [3:0] ho;
        logic [2:0] mt;
        logic [3:0] mo;
    } t_hhmm;

    typedef struct packed {
        t_hhmm hhmm;
        logic  en;
    } t_alarm;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] sel;
        logic [3:0] key;
        t_hhmm      now;
    } t_item;

    typedef struct packed {
        t_alarm [1:0] alarm;
        logic [1:0]   target;
        logic [1:0]   pos;
    } t_state;

    typedef struct packed {
        logic       ring;
        logic [1:0] editing;
        logic [1:0] cursor;
        t_alarm     shown;
    } t_result;

    // reset values: alarm 1 06:30, alarm 2 06:31, both off
    localparam t_alarm ALARM1_RESET = '{hhmm: '{ht: 2'd0, ho: 4'd6, mt: 3'd3, mo: 4'd0},
                                        en: 1'b0};
    localparam t_alarm ALARM2_RESET = '{hhmm: '{ht: 2'd0, ho: 4'd6, mt: 3'd3, mo: 4'd1},
                                        en: 1'b0};

endpackage

>>> src/atem_update.sv
// ----------------------------------------------------------------------------
// atem_update - next state and result for one word
// Digit entry with per-position checks, command keys, alarm match.
// ----------------------------------------------------------------------------
module atem_update (
    input  atem_pkg::t_item   i_item,
    input  atem_pkg::t_state  i_state,
    output atem_pkg::t_state  o_state,
    output atem_pkg::t_result o_result
);

    logic             idx;
    logic             n_idx;
    logic             ok;
    logic             editing;
    logic [3:0]       toggle_key;
    logic [3:0]       exit_key;
    atem_pkg::t_alarm cur;
    atem_pkg::t_state nx;
    logic             ring;

    always_comb begin
        nx         = i_state;
        ring       = 1'b0;
        ok         = 1'b0;
        idx        = (i_state.target == atem_pkg::EDIT_A2);
        cur        = i_state.alarm[idx];
        editing    = (i_state.target == atem_pkg::EDIT_A1) ||
                     (i_state.target == atem_pkg::EDIT_A2);
        toggle_key = (i_state.target == atem_pkg::EDIT_A1) ? atem_pkg::KEY_STAR
                                                           : atem_pkg::KEY_HASH;
        exit_key   = (i_state.target == atem_pkg::EDIT_A1) ? atem_pkg::KEY_HASH
                                                           : atem_pkg::KEY_STAR;

        // check digit against the cursor position
        case (i_state.pos)
            atem_pkg::POS_HT: begin
                ok = i_item.key < atem_pkg::HT_LIMIT;
            end
            atem_pkg::POS_HO: begin
                ok = ((i_item.key < atem_pkg::DIGIT_LIMIT) &&
                      (cur.hhmm.ht < atem_pkg::HT_TWENTY)) ||
                     ((i_item.key < atem_pkg::HO_LIMIT_20) &&
                      (cur.hhmm.ht == atem_pkg::HT_TWENTY));
            end
            atem_pkg::POS_MT: begin
                ok = i_item.key < atem_pkg::MT_LIMIT;
            end
            default: begin
                ok = i_item.key < atem_pkg::DIGIT_LIMIT;
            end
        endcase

        case (i_item.kind)
            atem_pkg::KIND_EDIT: begin
                if (i_item.sel == atem_pkg::EDIT_A1 || i_item.sel == atem_pkg::EDIT_A2) begin
                    nx.target = i_item.sel;
                end
            end
            atem_pkg::KIND_KEY: begin
                if (editing && ok) begin
                    // store digit, advance cursor with wrap
                    case (i_state.pos)
                        atem_pkg::POS_HT: nx.alarm[idx].hhmm.ht = i_item.key[1:0];
                        atem_pkg::POS_HO: nx.alarm[idx].hhmm.ho = i_item.key;
                        atem_pkg::POS_MT: nx.alarm[idx].hhmm.mt = i_item.key[2:0];
                        default:          nx.alarm[idx].hhmm.mo = i_item.key;
                    endcase
                    nx.pos = i_state.pos + 2'd1;
                end else if (editing) begin
                    // refused digit acts as a command
                    if (i_item.key == toggle_key) begin
                        nx.alarm[idx].en = ~cur.en;
                    end else if (i_item.key == exit_key) begin
                        nx.target = atem_pkg::EDIT_NONE;
                    end
                end
            end
            atem_pkg::KIND_TIME: begin
                ring = (i_state.alarm[0].en && (i_state.alarm[0].hhmm == i_item.now)) ||
                       (i_state.alarm[1].en && (i_state.alarm[1].hhmm == i_item.now));
            end
            default: begin
            end
        endcase
    end

    // result shows the state after the word
    assign n_idx            = (nx.target == atem_pkg::EDIT_A2);
    assign o_state          = nx;
    assign o_result.ring    = ring;
    assign o_result.editing = nx.target;
    assign o_result.cursor  = nx.pos;
    assign o_result.shown   = nx.alarm[n_idx];

endmodule

>>> src/alarm_time_entry_and_match_top.sv
// ----------------------------------------------------------------------------
// alarm_time_entry_and_match_top - two-alarm HH:MM entry and time match
// Input register, single-pass update, result register.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  input   | in        | i_valid / o_stall  | kind, alarm select, key, now
//  result  | out       | o_valid / i_stall  | ring, editing, cursor, shown
//
//  One word per cycle when not stalled; an accepted word is held in the
//  input register, then passes the update logic into the result register,
//  where o_valid marks it for the receiver.
//  Synchronous active-low reset clears both stages and loads alarm 1
//  06:30, alarm 2 06:31, both off, not editing, cursor at hour tens.
//  A stalled result holds the result register and a full input register;
//  o_stall rises only when the input register is full and cannot move on.
// ----------------------------------------------------------------------------
module alarm_time_entry_and_match_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_kind,
    input  logic [1:0] i_alarm_select,
    input  logic [3:0] i_key_code,
    input  logic [1:0] i_now_hour_tens,
    input  logic [3:0] i_now_hour_ones,
    input  logic [2:0] i_now_min_tens,
    input  logic [3:0] i_now_min_ones,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_ring,
    output logic [1:0] o_editing,
    output logic [1:0] o_cursor,
    output logic [1:0] o_shown_hour_tens,
    output logic [3:0] o_shown_hour_ones,
    output logic [2:0] o_shown_min_tens,
    output logic [3:0] o_shown_min_ones,
    output logic       o_shown_enabled
);

    logic              r_in_vld;
    atem_pkg::t_item   r_in;
    logic              r_out_vld;
    atem_pkg::t_result r_res;
    atem_pkg::t_state  r_state;
    atem_pkg::t_state  n_state;
    atem_pkg::t_result n_res;
    logic              adv;

    // pipeline advances when the result register is empty or being taken
    assign adv     = !r_out_vld || !i_stall;
    assign o_stall = r_in_vld && !adv;

    atem_update u_update (
        .i_item   (r_in),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_res)
    );

    // control and alarm state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
            r_state.alarm  <= {atem_pkg::ALARM2_RESET, atem_pkg::ALARM1_RESET};
            r_state.target <= atem_pkg::EDIT_NONE;
            r_state.pos    <= atem_pkg::POS_HT;
        end else begin
            if (!o_stall) begin
                r_in_vld <= i_valid;
            end
            if (adv) begin
                r_out_vld <= r_in_vld;
                if (r_in_vld) begin
                    r_state <= n_state;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in.kind    <= i_kind;
            r_in.sel     <= i_alarm_select;
            r_in.key     <= i_key_code;
            r_in.now.ht  <= i_now_hour_tens;
            r_in.now.ho  <= i_now_hour_ones;
            r_in.now.mt  <= i_now_min_tens;
            r_in.now.mo  <= i_now_min_ones;
        end
        if (adv && r_in_vld) begin
            r_res <= n_res;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_ring            = r_res.ring;
    assign o_editing         = r_res.editing;
    assign o_cursor          = r_res.cursor;
    assign o_shown_hour_tens = r_res.shown.hhmm.ht;
    assign o_shown_hour_ones = r_res.shown.hhmm.ho;
    assign o_shown_min_tens  = r_res.shown.hhmm.mt;
    assign o_shown_min_ones  = r_res.shown.hhmm.mo;
    assign o_shown_enabled   = r_res.shown.en;

    // edit target never takes the unused code
    a_target_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.target == atem_pkg::EDIT_NONE) ||
        (r_state.target == atem_pkg::EDIT_A1) ||
        (r_state.target == atem_pkg::EDIT_A2))
        else $error("edit target holds unused code");

    // stored hour tens digits stay at or below two
    a_hour_tens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.alarm[0].hhmm.ht <= atem_pkg::HT_TWENTY) &&
        (r_state.alarm[1].hhmm.ht <= atem_pkg::HT_TWENTY))
        else $error("stored hour tens out of range");

    // stall only with a full input register
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_vld)
        else $error("stall with empty input register");

    // cursor moves only when a key word passes the update
    a_cursor_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_state.pos != $past(r_state.pos))) |->
        ($past(adv && r_in_vld) && ($past(r_in.kind) == atem_pkg::KIND_KEY)))
        else $error("cursor moved without a key word");

endmodule
